@@ src/pd_motor_position_step_assert.svh @@
// Assertion macros shared by the checker. Both sample on clk and are
// disabled while rst_n is low.
`ifndef PD_MOTOR_POSITION_STEP_ASSERT_SVH
`define PD_MOTOR_POSITION_STEP_ASSERT_SVH

// Same-cycle implication
`define PDMPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PDMPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pdmps_pkg.sv @@
`timescale 1ns / 1ps

package pdmps_pkg;

  // Default encoder resolution
  localparam int COUNTS_PER_TURN_DEF = 64;
  localparam int DEG_PER_TURN = 360;

  // Field widths
  localparam int GOAL_W  = 28;
  localparam int ENC_W   = 24;
  localparam int DRIVE_W = 16;
  localparam int DUTY_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_DERIV_GAIN    = 3'd1,
    CFG_STEP_DEGREES  = 3'd2,
    CFG_INVERT_WIRING = 3'd3
  } pdmps_cfg_idx_t;

  // Input item
  typedef struct packed {
    logic signed [GOAL_W-1:0] goal_degrees;
    logic signed [ENC_W-1:0]  encoder_count;
  } pdmps_in_t;

  // Result item
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_value;
    logic                      pin_a_high;
    logic                      pin_b_high;
    logic [DUTY_W-1:0]         pwm_duty;
    logic signed [DRIVE_W-1:0] peak_drive;
  } pdmps_out_t;

  // Sequencer steps, most of which issue or consume a multiply
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PM,
    ST_DIFF,
    ST_MV,
    ST_QEST,
    ST_QMUL,
    ST_QCOR,
    ST_PSUM,
    ST_ERR,
    ST_KP,
    ST_KD,
    ST_DABS,
    ST_D10,
    ST_D10Q,
    ST_D10C,
    ST_DRV,
    ST_MAG,
    ST_X219,
    ST_X255,
    ST_QDUTY,
    ST_DUTY
  } pdmps_state_t;

endpackage

@@ src/pd_motor_position_step.sv @@
`timescale 1ns / 1ps

// PD position controller, one control tick per input transfer.
// Input channel in_valid/in_stall/in_data carries the goal angle and the
// encoder count; result channel out_valid/out_stall/out_data returns the
// drive command, direction pins, PWM duty and the running peak drive.
// Gains, step size and wiring inversion are written over cfg_valid/
// cfg_ready/cfg_index/cfg_data; cfg_ready is always high.
// Each tick: the sequencer walks 20 steps around a single shared 27x27
// signed multiplier whose product is registered, and in_stall stays high
// until the result sits in the output register.
// The output register frees the input side: a new tick is accepted while
// a result waits. If out_stall holds the previous result when the next
// one is ready, the sequencer waits in its last step until that transfer.
// Synchronous reset clears config, stored position, last drive, peak
// drive and the output valid; the block is ready on the first cycle after.
// Divisions by constants use reciprocal multiplies with one correction.
module pd_motor_position_step #(
  parameter int COUNTS_PER_TURN = pdmps_pkg::COUNTS_PER_TURN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pdmps_pkg::pdmps_in_t                in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pdmps_pkg::pdmps_out_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pdmps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdmps_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pdmps_pkg::*;

  // Degrees per count and its reciprocal for the back conversion
  localparam int DPC    = DEG_PER_TURN / COUNTS_PER_TURN;
  localparam int Q_SH   = 21;
  localparam int M_DPC  = (1 << Q_SH) / DPC;
  // Divide by ten for the derivative term
  localparam int D10_SH = 29;
  localparam int M10    = (1 << D10_SH) / 10;
  // Duty scaling
  localparam int DUTY_SH   = 25;
  localparam int M255      = (1 << DUTY_SH) / 255;
  localparam int DUTY_GAIN = 219;
  localparam int DUTY_DIV  = 255;
  localparam int DUTY_BASE = 36;
  localparam int MUL_W     = 27;

  // Configuration
  logic [9:0]  prop_r;
  logic [9:0]  deriv_r;
  logic [11:0] step_r;
  logic        inv_r;

  // Controller state
  logic signed [ENC_W-1:0]   lp_r, lp_nxt;
  logic signed [DRIVE_W-1:0] ld_r, ld_nxt;
  logic signed [DRIVE_W-1:0] max_r, max_nxt;

  pdmps_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  pdmps_out_t   out_r, out_nxt;

  // Working registers
  logic signed [GOAL_W-1:0]  goal_r, goal_nxt;
  logic signed [ENC_W-1:0]   pos_r, pos_nxt;
  logic signed [33:0]        d_r, d_nxt;
  logic                      up_r, up_nxt;
  logic [11:0]               mv_r, mv_nxt;
  logic [11:0]               q_r, q_nxt;
  logic                      rnz_r, rnz_nxt;
  logic signed [25:0]        psum_r, psum_nxt;
  logic signed [26:0]        err_r, err_nxt;
  logic signed [37:0]        p_r, p_nxt;
  logic                      dneg_r, dneg_nxt;
  logic [24:0]               dabs_r, dabs_nxt;
  logic [21:0]               q10_r, q10_nxt;
  logic signed [DRIVE_W-1:0] drv_r, drv_nxt;
  logic                      satd_r, satd_nxt;
  logic [8:0]                mag9_r, mag9_nxt;
  logic [16:0]               x_r, x_nxt;
  logic [8:0]                qd_r, qd_nxt;

  // Shared multiplier with registered product
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p, prod_r;

  // Step temporaries
  logic              lt_up, gt_dn;
  logic [11:0]       neg_lo;
  logic [12:0]       rq;
  logic [12:0]       rq2;
  logic signed [26:0] adj;
  logic signed [26:0] dx;
  logic [24:0]       r10;
  logic signed [38:0] drv_x;
  logic [15:0]       mag;
  logic [16:0]       rd;
  logic [9:0]        qd_c;
  logic [9:0]        duty_sum;
  logic              out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign mul_p = mul_a * mul_b;

  // Sequencer, operand select and datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    lp_nxt        = lp_r;
    ld_nxt        = ld_r;
    max_nxt       = max_r;
    goal_nxt      = goal_r;
    pos_nxt       = pos_r;
    d_nxt         = d_r;
    up_nxt        = up_r;
    mv_nxt        = mv_r;
    q_nxt         = q_r;
    rnz_nxt       = rnz_r;
    psum_nxt      = psum_r;
    err_nxt       = err_r;
    p_nxt         = p_r;
    dneg_nxt      = dneg_r;
    dabs_nxt      = dabs_r;
    q10_nxt       = q10_r;
    drv_nxt       = drv_r;
    satd_nxt      = satd_r;
    mag9_nxt      = mag9_r;
    x_nxt         = x_r;
    qd_nxt        = qd_r;
    mul_a         = '0;
    mul_b         = '0;

    lt_up    = d_r < $signed({22'd0, step_r});
    gt_dn    = d_r > -$signed({22'd0, step_r});
    neg_lo   = ~d_r[11:0] + 12'd1;
    rq       = {1'b0, mv_r} - prod_r[12:0];
    rq2      = rq - 13'(DPC);
    adj      = '0;
    dx       = $signed(prod_r[26:0]);
    r10      = dabs_r - prod_r[24:0];
    drv_x    = dneg_r ? (39'(p_r) + 39'(q10_r)) : (39'(p_r) - 39'(q10_r));
    mag      = drv_r[DRIVE_W-1] ? 16'(-drv_r) : 16'(drv_r);
    rd       = x_r - prod_r[16:0];
    qd_c     = {1'b0, qd_r} + ((rd >= 17'(DUTY_DIV)) ? 10'd1 : 10'd0);
    duty_sum = qd_c + 10'(DUTY_BASE);

    // Drop the result register once its transfer completes
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          goal_nxt  = in_data.goal_degrees;
          pos_nxt   = inv_r ? -in_data.encoder_count : in_data.encoder_count;
          state_nxt = ST_PM;
        end
      end
      // Stored position to degrees
      ST_PM: begin
        mul_a     = MUL_W'(lp_r);
        mul_b     = MUL_W'(DPC);
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        d_nxt     = 34'(goal_r) - 34'($signed(prod_r[32:0]));
        state_nxt = ST_MV;
      end
      // Limit the move to the step size
      ST_MV: begin
        up_nxt = !d_r[33];
        if (!d_r[33]) begin
          mv_nxt = lt_up ? d_r[11:0] : step_r;
        end else begin
          mv_nxt = gt_dn ? neg_lo : step_r;
        end
        state_nxt = ST_QEST;
      end
      // Move back to counts: quotient estimate, then check by multiply
      ST_QEST: begin
        mul_a     = MUL_W'(mv_r);
        mul_b     = MUL_W'(M_DPC);
        state_nxt = ST_QMUL;
      end
      ST_QMUL: begin
        q_nxt     = prod_r[Q_SH +: 12];
        mul_a     = MUL_W'(prod_r[Q_SH +: 12]);
        mul_b     = MUL_W'(DPC);
        state_nxt = ST_QCOR;
      end
      ST_QCOR: begin
        if (rq >= 13'(DPC)) begin
          q_nxt   = q_r + 12'd1;
          rnz_nxt = (rq2 != 13'd0);
        end else begin
          rnz_nxt = (rq != 13'd0);
        end
        state_nxt = ST_PSUM;
      end
      ST_PSUM: begin
        psum_nxt  = up_r ? (26'(lp_r) + 26'(q_r)) : (26'(lp_r) - 26'(q_r));
        state_nxt = ST_ERR;
      end
      // Truncation toward zero of the leftover degrees, then error
      ST_ERR: begin
        if (up_r && psum_r[25] && rnz_r) begin
          adj = 27'sd1;
        end else if (!up_r && !psum_r[25] && (psum_r != 26'sd0) && rnz_r) begin
          adj = -27'sd1;
        end
        err_nxt   = 27'(psum_r) - 27'(pos_r) + adj;
        state_nxt = ST_KP;
      end
      ST_KP: begin
        mul_a     = MUL_W'(prop_r);
        mul_b     = err_r;
        state_nxt = ST_KD;
      end
      ST_KD: begin
        p_nxt     = $signed(prod_r[37:0]);
        mul_a     = MUL_W'(deriv_r);
        mul_b     = MUL_W'(ld_r);
        state_nxt = ST_DABS;
      end
      // Derivative term divided by ten on its magnitude
      ST_DABS: begin
        dneg_nxt  = dx[26];
        dabs_nxt  = dx[26] ? 25'(-dx) : 25'(dx);
        state_nxt = ST_D10;
      end
      ST_D10: begin
        mul_a     = MUL_W'(dabs_r);
        mul_b     = MUL_W'(M10);
        state_nxt = ST_D10Q;
      end
      ST_D10Q: begin
        q10_nxt   = prod_r[D10_SH +: 22];
        mul_a     = MUL_W'(prod_r[D10_SH +: 22]);
        mul_b     = MUL_W'(10);
        state_nxt = ST_D10C;
      end
      ST_D10C: begin
        if (r10 >= 25'd10) begin
          q10_nxt = q10_r + 22'd1;
        end
        state_nxt = ST_DRV;
      end
      // Drive with saturation
      ST_DRV: begin
        if (drv_x > 39'sd32767) begin
          drv_nxt = 16'sh7FFF;
        end else if (drv_x < -39'sd32768) begin
          drv_nxt = 16'sh8000;
        end else begin
          drv_nxt = drv_x[15:0];
        end
        ld_nxt    = drv_nxt;
        state_nxt = ST_MAG;
      end
      ST_MAG: begin
        if (drv_r > max_r) begin
          max_nxt = drv_r;
        end
        satd_nxt  = |mag[15:9];
        mag9_nxt  = mag[8:0];
        state_nxt = ST_X219;
      end
      // Duty: 36 + |drive| * 219 / 255, capped at 255; magnitudes from 512 up always clip
      ST_X219: begin
        mul_a     = MUL_W'(mag9_r);
        mul_b     = MUL_W'(DUTY_GAIN);
        state_nxt = ST_X255;
      end
      ST_X255: begin
        x_nxt     = prod_r[16:0];
        mul_a     = MUL_W'(prod_r[16:0]);
        mul_b     = MUL_W'(M255);
        state_nxt = ST_QDUTY;
      end
      ST_QDUTY: begin
        qd_nxt    = prod_r[DUTY_SH +: 9];
        mul_a     = MUL_W'(prod_r[DUTY_SH +: 9]);
        mul_b     = MUL_W'(DUTY_DIV);
        state_nxt = ST_DUTY;
      end
      // Load the result once the output register is free; keep the
      // quotient check product in place while waiting
      ST_DUTY: begin
        mul_a = MUL_W'(qd_r);
        mul_b = MUL_W'(DUTY_DIV);
        if (out_free) begin
          out_nxt.drive_value = drv_r;
          out_nxt.pin_a_high  = inv_r ? (drv_r > 16'sd0) : drv_r[DRIVE_W-1];
          out_nxt.pin_b_high  = inv_r ? drv_r[DRIVE_W-1] : (drv_r > 16'sd0);
          out_nxt.pwm_duty    = (satd_r || (duty_sum > 10'd255)) ? 8'hFF
                                                                 : duty_sum[7:0];
          out_nxt.peak_drive  = max_r;
          out_valid_nxt       = 1'b1;
          lp_nxt              = pos_r;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prop_r      <= '0;
      deriv_r     <= '0;
      step_r      <= '0;
      inv_r       <= 1'b0;
      lp_r        <= '0;
      ld_r        <= '0;
      max_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lp_r        <= lp_nxt;
      ld_r        <= ld_nxt;
      max_r       <= max_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:     prop_r  <= cfg_data[9:0];
          CFG_DERIV_GAIN:    deriv_r <= cfg_data[9:0];
          CFG_STEP_DEGREES:  step_r  <= cfg_data[11:0];
          CFG_INVERT_WIRING: inv_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    out_r  <= out_nxt;
    goal_r <= goal_nxt;
    pos_r  <= pos_nxt;
    d_r    <= d_nxt;
    up_r   <= up_nxt;
    mv_r   <= mv_nxt;
    q_r    <= q_nxt;
    rnz_r  <= rnz_nxt;
    psum_r <= psum_nxt;
    err_r  <= err_nxt;
    p_r    <= p_nxt;
    dneg_r <= dneg_nxt;
    dabs_r <= dabs_nxt;
    q10_r  <= q10_nxt;
    drv_r  <= drv_nxt;
    satd_r <= satd_nxt;
    mag9_r <= mag9_nxt;
    x_r    <= x_nxt;
    qd_r   <= qd_nxt;
  end

endmodule

@@ src/pdmps_checker.sv @@
`timescale 1ns / 1ps

module pdmps_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input pdmps_pkg::pdmps_out_t out_data
);
  import pdmps_pkg::*;

  `include "pd_motor_position_step_assert.svh"

  // A held result keeps its payload
  `PDMPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // One tick at a time: busy right after an input transfer
  `PDMPS_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "accepted a second tick while busy")

  // Direction pins never both high, zero drive gives idle pins and base duty
  `PDMPS_ASSERT_NOW(a_pins, out_valid, !(out_data.pin_a_high && out_data.pin_b_high) && ((out_data.drive_value != 16'sd0) || (!out_data.pin_a_high && !out_data.pin_b_high && (out_data.pwm_duty == 8'd36))), "pin or duty mismatch")

  // Peak is never negative and never below the drive just reported
  `PDMPS_ASSERT_NOW(a_peak, out_valid, !out_data.peak_drive[15] && (out_data.peak_drive >= out_data.drive_value), "peak drive below drive")

endmodule

bind pd_motor_position_step pdmps_checker u_pdmps_checker (.*);
